/* hdl/tcc_pkg.sv */
// Shared types for the triangle circumcentre block.
`default_nettype none
package tcc_pkg;

  // Control word that travels alongside each request down the pipeline.
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage
`default_nettype wire

/* hdl/tcc_front.sv */
// Front end: edge vectors, squared lengths, cross product, numerators and magnitudes.
`default_nettype none
module tcc_front import tcc_pkg::*; #(
  parameter int CW  = 16,
  parameter int MW  = 3 * CW + 2,
  parameter int DMW = 2 * CW + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic signed [CW-1:0]  a_x_i,
  input  wire logic signed [CW-1:0]  a_y_i,
  input  wire logic signed [CW-1:0]  b_x_i,
  input  wire logic signed [CW-1:0]  b_y_i,
  input  wire logic signed [CW-1:0]  c_x_i,
  input  wire logic signed [CW-1:0]  c_y_i,
  output ctl_t                       ctl_o,
  output logic signed [CW-1:0]       a_x_o,
  output logic signed [CW-1:0]       a_y_o,
  output logic [DMW-1:0]             den_o,
  output logic [MW-1:0]              nx_o,
  output logic [MW-1:0]              ny_o
);

  localparam int DW = CW + 1;
  localparam int LW = 2 * DW;
  localparam int NW = DW + LW;
  localparam int KW = LW + 1;

  logic [5:0] vld_q;
  logic signed [CW-1:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [CW-1:0] ax4_q, ay4_q, ax5_q, ay5_q, ax6_q, ay6_q;

  // Stage 1: edge vectors.
  logic signed [DW-1:0] dx1_q, dy1_q, ex1_q, ey1_q;
  // Stage 2: products.
  logic signed [LW-1:0] pdd_q, pdy_q, pee_q, pey_q, pk1_q, pk2_q;
  logic signed [DW-1:0] dx2_q, dy2_q, ex2_q, ey2_q;
  // Stage 3: squared lengths and cross product.
  logic signed [LW-1:0] bl_q, cl_q, k_q;
  logic signed [DW-1:0] dx3_q, dy3_q, ex3_q, ey3_q;
  // Stage 4: numerator products and doubled cross product.
  logic signed [NW-1:0] px1_q, px2_q, py1_q, py2_q;
  logic signed [KW-1:0] den4_q;
  // Stage 5: signed numerators.
  logic signed [NW-1:0] nx5_q, ny5_q;
  logic signed [KW-1:0] den5_q;
  // Stage 6: magnitudes.
  logic [MW-1:0]  nx6_q, ny6_q;
  logic [DMW-1:0] den6_q;
  logic           degen6_q, negx6_q, negy6_q;

  logic signed [NW-1:0] nx_abs, ny_abs;
  logic signed [KW-1:0] den_abs;

  assign nx_abs  = nx5_q[NW-1] ? -nx5_q : nx5_q;
  assign ny_abs  = ny5_q[NW-1] ? -ny5_q : ny5_q;
  assign den_abs = den5_q[KW-1] ? -den5_q : den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q <= a_x_i;
    ay1_q <= a_y_i;
    dx1_q <= DW'(b_x_i) - DW'(a_x_i);
    dy1_q <= DW'(b_y_i) - DW'(a_y_i);
    ex1_q <= DW'(c_x_i) - DW'(a_x_i);
    ey1_q <= DW'(c_y_i) - DW'(a_y_i);

    ax2_q <= ax1_q;
    ay2_q <= ay1_q;
    pdd_q <= LW'(dx1_q * dx1_q) + LW'(0);
    pdy_q <= dy1_q * dy1_q;
    pee_q <= ex1_q * ex1_q;
    pey_q <= ey1_q * ey1_q;
    pk1_q <= dx1_q * ey1_q;
    pk2_q <= dy1_q * ex1_q;
    dx2_q <= dx1_q;
    dy2_q <= dy1_q;
    ex2_q <= ex1_q;
    ey2_q <= ey1_q;

    ax3_q <= ax2_q;
    ay3_q <= ay2_q;
    bl_q  <= pdd_q + pdy_q;
    cl_q  <= pee_q + pey_q;
    k_q   <= pk1_q - pk2_q;
    dx3_q <= dx2_q;
    dy3_q <= dy2_q;
    ex3_q <= ex2_q;
    ey3_q <= ey2_q;

    ax4_q  <= ax3_q;
    ay4_q  <= ay3_q;
    px1_q  <= ey3_q * bl_q;
    px2_q  <= dy3_q * cl_q;
    py1_q  <= dx3_q * cl_q;
    py2_q  <= ex3_q * bl_q;
    den4_q <= $signed({k_q, 1'b0});

    ax5_q  <= ax4_q;
    ay5_q  <= ay4_q;
    nx5_q  <= px1_q - px2_q;
    ny5_q  <= py1_q - py2_q;
    den5_q <= den4_q;

    ax6_q    <= ax5_q;
    ay6_q    <= ay5_q;
    nx6_q    <= nx_abs[MW-1:0];
    ny6_q    <= ny_abs[MW-1:0];
    den6_q   <= den_abs[DMW-1:0];
    degen6_q <= (den5_q == '0);
    negx6_q  <= nx5_q[NW-1] ^ den5_q[KW-1];
    negy6_q  <= ny5_q[NW-1] ^ den5_q[KW-1];
  end

  always_comb begin
    ctl_o.valid = vld_q[5];
    ctl_o.degen = degen6_q;
    ctl_o.neg_x = negx6_q;
    ctl_o.neg_y = negy6_q;
  end

  assign a_x_o = ax6_q;
  assign a_y_o = ay6_q;
  assign den_o = den6_q;
  assign nx_o  = nx6_q;
  assign ny_o  = ny6_q;

endmodule
`default_nettype wire

/* hdl/tcc_cell.sv */
// One restoring division step for both coordinates; quotient bits shift into the numerator.
`default_nettype none
module tcc_cell import tcc_pkg::*; #(
  parameter int CW  = 16,
  parameter int MW  = 3 * CW + 2,
  parameter int DMW = 2 * CW + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctl_t                  ctl_i,
  input  wire logic signed [CW-1:0]  a_x_i,
  input  wire logic signed [CW-1:0]  a_y_i,
  input  wire logic [DMW-1:0]        den_i,
  input  wire logic [MW-1:0]         nx_i,
  input  wire logic [MW-1:0]         ny_i,
  input  wire logic [DMW-1:0]        rx_i,
  input  wire logic [DMW-1:0]        ry_i,
  output ctl_t                       ctl_o,
  output logic signed [CW-1:0]       a_x_o,
  output logic signed [CW-1:0]       a_y_o,
  output logic [DMW-1:0]             den_o,
  output logic [MW-1:0]              nx_o,
  output logic [MW-1:0]              ny_o,
  output logic [DMW-1:0]             rx_o,
  output logic [DMW-1:0]             ry_o
);

  logic [DMW:0] trial_x, trial_y, diff_x, diff_y;
  logic         fit_x, fit_y;

  assign trial_x = {rx_i, nx_i[MW-1]};
  assign trial_y = {ry_i, ny_i[MW-1]};
  assign diff_x  = trial_x - {1'b0, den_i};
  assign diff_y  = trial_y - {1'b0, den_i};
  assign fit_x   = !diff_x[DMW];
  assign fit_y   = !diff_y[DMW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_x_o <= a_x_i;
    a_y_o <= a_y_i;
    den_o <= den_i;
    nx_o  <= {nx_i[MW-2:0], fit_x};
    ny_o  <= {ny_i[MW-2:0], fit_y};
    rx_o  <= fit_x ? diff_x[DMW-1:0] : trial_x[DMW-1:0];
    ry_o  <= fit_y ? diff_y[DMW-1:0] : trial_y[DMW-1:0];
  end

endmodule
`default_nettype wire

/* hdl/triangle_circumcenter.sv */
// Top level: front end, chain of divider cells, sign and saturation back end.
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------------------
//  request   | start_i / busy_o  | a_x_i a_y_i b_x_i b_y_i c_x_i c_y_i
//  result    | valid_o strobe    | center_x_o center_y_o degenerate_o clipped_o
//
// A request is taken every cycle; busy_o stays low. Each result passes through
// six front-end stages, one divider cell per quotient bit (3*COORD_BITS+2 cells)
// and two back-end stages. Reset clears only the valid bits and the divider cells'
// control words along the pipeline. The receiver cannot stall.
`default_nettype none
module triangle_circumcenter import tcc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int OUT_BITS   = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] a_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_y_i,
  input  wire logic signed [COORD_BITS-1:0] c_x_i,
  input  wire logic signed [COORD_BITS-1:0] c_y_i,
  output logic                              valid_o,
  output logic signed [OUT_BITS-1:0]        center_x_o,
  output logic signed [OUT_BITS-1:0]        center_y_o,
  output logic                              degenerate_o,
  output logic                              clipped_o
);

  localparam int CW  = COORD_BITS;
  localparam int MW  = 3 * CW + 2;
  localparam int DMW = 2 * CW + 2;
  localparam int SW  = MW + 2;
  localparam int EW  = (SW > OUT_BITS) ? SW : OUT_BITS + 1;

  ctl_t                 ch_ctl [0:MW];
  logic signed [CW-1:0] ch_ax  [0:MW];
  logic signed [CW-1:0] ch_ay  [0:MW];
  logic [DMW-1:0]       ch_den [0:MW];
  logic [MW-1:0]        ch_nx  [0:MW];
  logic [MW-1:0]        ch_ny  [0:MW];
  logic [DMW-1:0]       ch_rx  [0:MW];
  logic [DMW-1:0]       ch_ry  [0:MW];

  assign busy_o = 1'b0;

  tcc_front #(.CW(CW), .MW(MW), .DMW(DMW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .ctl_o   (ch_ctl[0]),
    .a_x_o   (ch_ax[0]),
    .a_y_o   (ch_ay[0]),
    .den_o   (ch_den[0]),
    .nx_o    (ch_nx[0]),
    .ny_o    (ch_ny[0])
  );

  assign ch_rx[0] = '0;
  assign ch_ry[0] = '0;

  for (genvar i = 0; i < MW; i++) begin : g_cell
    tcc_cell #(.CW(CW), .MW(MW), .DMW(DMW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ch_ctl[i]),
      .a_x_i  (ch_ax[i]),
      .a_y_i  (ch_ay[i]),
      .den_i  (ch_den[i]),
      .nx_i   (ch_nx[i]),
      .ny_i   (ch_ny[i]),
      .rx_i   (ch_rx[i]),
      .ry_i   (ch_ry[i]),
      .ctl_o  (ch_ctl[i+1]),
      .a_x_o  (ch_ax[i+1]),
      .a_y_o  (ch_ay[i+1]),
      .den_o  (ch_den[i+1]),
      .nx_o   (ch_nx[i+1]),
      .ny_o   (ch_ny[i+1]),
      .rx_o   (ch_rx[i+1]),
      .ry_o   (ch_ry[i+1])
    );
  end

  // After the last cell the numerator registers hold the quotient magnitudes.
  logic signed [SW-1:0] ax_ext, ay_ext, qx_ext, qy_ext;
  logic signed [SW-1:0] sum_x_d, sum_y_d, sum_x_q, sum_y_q;
  logic                 vld1_q, degen1_q;

  assign ax_ext  = SW'(ch_ax[MW]);
  assign ay_ext  = SW'(ch_ay[MW]);
  assign qx_ext  = $signed({2'b00, ch_nx[MW]});
  assign qy_ext  = $signed({2'b00, ch_ny[MW]});
  assign sum_x_d = ch_ctl[MW].degen ? ax_ext :
                   (ch_ctl[MW].neg_x ? ax_ext - qx_ext : ax_ext + qx_ext);
  assign sum_y_d = ch_ctl[MW].degen ? ay_ext :
                   (ch_ctl[MW].neg_y ? ay_ext - qy_ext : ay_ext + qy_ext);

  logic signed [EW-1:0]       sx_ext, sy_ext;
  logic                       ovf_x, ovf_y;
  logic signed [OUT_BITS-1:0] sat_x, sat_y, out_max, out_min;

  assign sx_ext  = EW'(sum_x_q);
  assign sy_ext  = EW'(sum_y_q);
  assign ovf_x   = (sx_ext[EW-1:OUT_BITS-1] != '0) && (sx_ext[EW-1:OUT_BITS-1] != '1);
  assign ovf_y   = (sy_ext[EW-1:OUT_BITS-1] != '0) && (sy_ext[EW-1:OUT_BITS-1] != '1);
  assign out_max = {1'b0, {(OUT_BITS-1){1'b1}}};
  assign out_min = {1'b1, {(OUT_BITS-1){1'b0}}};
  assign sat_x   = ovf_x ? (sx_ext[EW-1] ? out_min : out_max) : sx_ext[OUT_BITS-1:0];
  assign sat_y   = ovf_y ? (sy_ext[EW-1] ? out_min : out_max) : sy_ext[OUT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vld1_q  <= ch_ctl[MW].valid;
      valid_o <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_x_q      <= sum_x_d;
    sum_y_q      <= sum_y_d;
    degen1_q     <= ch_ctl[MW].degen;
    center_x_o   <= sat_x;
    center_y_o   <= sat_y;
    degenerate_o <= degen1_q;
    clipped_o    <= ovf_x || ovf_y;
  end

endmodule
`default_nettype wire

/* hdl/tcc_checker.sv */
// Port-level checks for the triangle circumcentre block, bound to the top level.
`default_nettype none
module tcc_checker #(
  parameter int COORD_BITS = 16,
  parameter int OUT_BITS   = 32
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic                         valid_o,
  input wire logic signed [OUT_BITS-1:0]   center_x_o,
  input wire logic signed [OUT_BITS-1:0]   center_y_o,
  input wire logic                         degenerate_o,
  input wire logic                         clipped_o
);

  localparam int LAT = 3 * COORD_BITS + 10;

  logic x_ext, y_ext;
  assign x_ext = (center_x_o == {1'b0, {(OUT_BITS-1){1'b1}}}) ||
                 (center_x_o == {1'b1, {(OUT_BITS-1){1'b0}}});
  assign y_ext = (center_y_o == {1'b0, {(OUT_BITS-1){1'b1}}}) ||
                 (center_y_o == {1'b1, {(OUT_BITS-1){1'b0}}});

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised on a fully pipelined block");

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LAT))
    else $error("result without a matching request");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && clipped_o |-> x_ext || y_ext)
    else $error("clipped result not at a range limit");

  a_degen_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> !clipped_o || (OUT_BITS < COORD_BITS))
    else $error("collinear result clipped although the vertex fits");

endmodule

bind triangle_circumcenter tcc_checker #(
  .COORD_BITS(COORD_BITS),
  .OUT_BITS  (OUT_BITS)
) u_tcc_checker (.*);
`default_nettype wire
